@@ src/bppm_pkg.sv @@
package bppm_pkg;

    // field widths of the request and response words
    localparam int ACTION_W = 1;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 16;
    localparam int CAP_W    = 5;

    // capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_FIX   = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_UNFIX = 1'b1;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALL_PINNED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_PINNED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd5;

    // write controls for the slot store
    typedef struct packed {
        logic key_we;
        logic cnt_we;
        logic set_valid;
    } t_store_wr;

endpackage

@@ src/bppm_if.sv @@
// request channel: action and block key
interface bppm_req_if;
    import bppm_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    block_key;

    modport source (output valid, output action, output block_key, input ready);
    modport sink   (input valid, input action, input block_key, output ready);
endinterface

// response channel: one word per request
interface bppm_rsp_if;
    import bppm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  pin_count_now;
    logic                evicted_valid;
    logic [KEY_W-1:0]    evicted_key;

    modport source (output valid, output status, output slot, output pin_count_now,
                    output evicted_valid, output evicted_key, input ready);
    modport sink   (input valid, input status, input slot, input pin_count_now,
                    input evicted_valid, input evicted_key, output ready);
endinterface

@@ src/bppm_slot_store.sv @@
module bppm_slot_store #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [$clog2(SLOTS)-1:0]  i_rd_addr,
    input  logic [$clog2(SLOTS)-1:0]  i_wr_addr,
    input  bppm_pkg::t_store_wr       i_wr_ctl,
    input  logic [KEY_BITS-1:0]       i_wr_key,
    input  logic [COUNT_BITS-1:0]     i_wr_cnt,
    output logic [KEY_BITS-1:0]       o_rd_key,
    output logic [COUNT_BITS-1:0]     o_rd_cnt,
    output logic [SLOTS-1:0]          o_valid
);
    import bppm_pkg::*;

    logic [KEY_BITS-1:0]   r_key_mem [SLOTS];
    logic [COUNT_BITS-1:0] r_cnt_mem [SLOTS];
    logic [SLOTS-1:0]      r_valid;

    // key and count memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.key_we) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_wr_ctl.cnt_we) begin
            r_cnt_mem[i_wr_addr] <= i_wr_cnt;
        end
        o_rd_key <= r_key_mem[i_rd_addr];
        o_rd_cnt <= r_cnt_mem[i_rd_addr];
    end

    // slot valid bits, cleared by reset and never freed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_ctl.set_valid) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_valid = r_valid;

endmodule

@@ src/buffer_pool_pin_manager.sv @@
// sequence: each slot key is read (S_SRD) and compared (S_SCMP) until a hit (a miss scans all
//   slots), then S_COMMIT; leaving the queue searches it (S_QRD, S_QCMP) and shifts the entries
//   behind (S_SHRD, S_SHWR); an eviction first reads the queue head, then its slot and key
// flow: one request at a time, ready in the cycle after commit, commit waits on the response
// reset: synchronous, active low; clears valid bits, queue length, used count, and sets
//   capacity to 16; key, count and queue memories need no clearing pass
module buffer_pool_pin_manager #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [bppm_pkg::CAP_W-1:0] i_cfg_wr_data,
    bppm_req_if.sink                   i_req,
    bppm_rsp_if.source                 o_rsp
);
    import bppm_pkg::*;

    localparam int SW   = $clog2(SLOTS);
    localparam int QW   = SW + 1;
    localparam int SK   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int CMPW = (QW > CAP_W) ? QW : CAP_W;
    localparam logic [SW-1:0]   LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [CMPW-1:0] SLOTS_C   = CMPW'(SLOTS);
    localparam logic [QW-1:0]   SLOTS_Q   = QW'(SLOTS);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRD    = 4'd1;
    localparam logic [3:0] S_SCMP   = 4'd2;
    localparam logic [3:0] S_QRD    = 4'd3;
    localparam logic [3:0] S_QCMP   = 4'd4;
    localparam logic [3:0] S_SHRD   = 4'd5;
    localparam logic [3:0] S_SHWR   = 4'd6;
    localparam logic [3:0] S_EVRD   = 4'd7;
    localparam logic [3:0] S_EVSLOT = 4'd8;
    localparam logic [3:0] S_EVKEY  = 4'd9;
    localparam logic [3:0] S_COMMIT = 4'd10;

    logic [3:0]            r_state,    n_state;
    logic [ACTION_W-1:0]   r_action,   n_action;
    logic [SK-1:0]         r_key,      n_key;
    logic [SW-1:0]         r_idx,      n_idx;
    logic [SW-1:0]         r_free,     n_free;
    logic                  r_free_ok,  n_free_ok;
    logic [SW-1:0]         r_slot,     n_slot;
    logic [COUNT_BITS-1:0] r_cnt,      n_cnt;
    logic [SW-1:0]         r_qi,       n_qi;
    logic [QW-1:0]         r_qlen,     n_qlen;
    logic [QW-1:0]         r_used,     n_used;
    logic [CAP_W-1:0]      r_cap;
    logic [STATUS_W-1:0]   r_status,   n_status;
    logic                  r_evict,    n_evict;
    logic [SK-1:0]         r_old_key,  n_old_key;
    logic                  r_key_we,   n_key_we;
    logic                  r_cnt_we,   n_cnt_we;
    logic                  r_set_val,  n_set_val;
    logic                  r_q_append, n_q_append;

    logic                  r_o_valid;
    logic [STATUS_W-1:0]   r_o_status;
    logic [SLOT_W-1:0]     r_o_slot;
    logic [COUNT_W-1:0]    r_o_count;
    logic                  r_o_evict;
    logic [KEY_W-1:0]      r_o_key;

    logic [SW-1:0]         r_queue [SLOTS];
    logic [SW-1:0]         r_q_rd;

    logic [SK-1:0]         w_rd_key;
    logic [COUNT_BITS-1:0] w_rd_cnt;
    logic [SLOTS-1:0]      w_valid;
    logic [SW-1:0]         w_store_ra;
    t_store_wr             w_wr_ctl;
    logic                  w_commit;
    logic                  w_accept;
    logic                  w_hit;
    logic                  w_free_ok_now;
    logic [SW-1:0]         w_free_now;
    logic [CMPW-1:0]       w_eff_cap;
    logic [CMPW-1:0]       w_used_ext;
    logic                  w_room;
    logic                  w_q_we;
    logic [SW-1:0]         w_q_wa;
    logic [SW-1:0]         w_q_wd;
    logic [SW-1:0]         w_q_ra;
    logic [SLOT_W+SW-1:0]           w_slot_ext;
    logic [COUNT_W+COUNT_BITS-1:0]  w_cnt_ext;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_commit = (r_state == S_COMMIT) && (!r_o_valid || o_rsp.ready);

    // slot key and count store
    assign w_store_ra = (r_state == S_EVSLOT) ? r_q_rd : r_idx;
    assign w_wr_ctl.key_we    = w_commit && r_key_we;
    assign w_wr_ctl.cnt_we    = w_commit && r_cnt_we;
    assign w_wr_ctl.set_valid = w_commit && r_set_val;

    bppm_slot_store #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (SK),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_store_ra),
        .i_wr_addr (r_slot),
        .i_wr_ctl  (w_wr_ctl),
        .i_wr_key  (r_key),
        .i_wr_cnt  (r_cnt),
        .o_rd_key  (w_rd_key),
        .o_rd_cnt  (w_rd_cnt),
        .o_valid   (w_valid)
    );

    // replacement queue memory, oldest unpinned slot at position zero
    always_comb begin
        case (r_state)
            S_SHRD:  w_q_ra = r_qi + SW'(1);
            S_EVRD:  w_q_ra = '0;
            default: w_q_ra = r_qi;
        endcase
    end

    assign w_q_we = (r_state == S_SHWR) || (w_commit && r_q_append && (r_qlen < SLOTS_Q));
    assign w_q_wa = (r_state == S_SHWR) ? r_qi : r_qlen[SW-1:0];
    assign w_q_wd = (r_state == S_SHWR) ? r_q_rd : r_slot;

    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            r_queue[w_q_wa] <= w_q_wd;
        end
        r_q_rd <= r_queue[w_q_ra];
    end

    // compare of the slot just read, and free slot tracking
    assign w_hit         = w_valid[r_idx] && (w_rd_key == r_key);
    assign w_free_ok_now = r_free_ok || !w_valid[r_idx];
    assign w_free_now    = r_free_ok ? r_free : r_idx;

    // effective capacity limited to one .. slot count
    assign w_eff_cap  = (r_cap == '0) ? CMPW'(1) : CMPW'(r_cap);
    assign w_used_ext = CMPW'(r_used);
    assign w_room     = (w_used_ext < w_eff_cap) && (w_used_ext < SLOTS_C);

    // request sequencer
    always_comb begin
        n_state    = r_state;
        n_action   = r_action;
        n_key      = r_key;
        n_idx      = r_idx;
        n_free     = r_free;
        n_free_ok  = r_free_ok;
        n_slot     = r_slot;
        n_cnt      = r_cnt;
        n_qi       = r_qi;
        n_qlen     = r_qlen;
        n_used     = r_used;
        n_status   = r_status;
        n_evict    = r_evict;
        n_old_key  = r_old_key;
        n_key_we   = r_key_we;
        n_cnt_we   = r_cnt_we;
        n_set_val  = r_set_val;
        n_q_append = r_q_append;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_action   = i_req.action;
                    n_key      = i_req.block_key[SK-1:0];
                    n_idx      = '0;
                    n_free_ok  = 1'b0;
                    n_slot     = '0;
                    n_cnt      = '0;
                    n_evict    = 1'b0;
                    n_old_key  = '0;
                    n_key_we   = 1'b0;
                    n_cnt_we   = 1'b0;
                    n_set_val  = 1'b0;
                    n_q_append = 1'b0;
                    n_state    = S_SRD;
                end
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (w_hit) begin
                    if (r_action == ACT_FIX) begin
                        n_slot = r_idx;
                        if (&w_rd_cnt) begin
                            n_cnt    = w_rd_cnt;
                            n_status = ST_OVERFLOW;
                            n_state  = S_COMMIT;
                        end else begin
                            n_cnt    = w_rd_cnt + COUNT_BITS'(1);
                            n_cnt_we = 1'b1;
                            n_status = ST_HIT;
                            n_qi     = '0;
                            // a re-fixed unpinned slot leaves the queue first
                            n_state  = (w_rd_cnt == '0) ? S_QRD : S_COMMIT;
                        end
                    end else if (w_rd_cnt == '0) begin
                        n_status = ST_NOT_PINNED;
                        n_state  = S_COMMIT;
                    end else begin
                        n_slot     = r_idx;
                        n_cnt      = w_rd_cnt - COUNT_BITS'(1);
                        n_cnt_we   = 1'b1;
                        n_status   = ST_HIT;
                        n_q_append = (w_rd_cnt == COUNT_BITS'(1));
                        n_state    = S_COMMIT;
                    end
                end else begin
                    n_free    = w_free_now;
                    n_free_ok = w_free_ok_now;
                    if (r_idx != LAST_SLOT) begin
                        n_idx   = r_idx + SW'(1);
                        n_state = S_SRD;
                    end else if (r_action == ACT_UNFIX) begin
                        n_status = ST_NOT_PINNED;
                        n_state  = S_COMMIT;
                    end else if (w_room && w_free_ok_now) begin
                        n_slot    = w_free_now;
                        n_cnt     = COUNT_BITS'(1);
                        n_key_we  = 1'b1;
                        n_cnt_we  = 1'b1;
                        n_set_val = 1'b1;
                        n_status  = ST_INSERTED;
                        n_state   = S_COMMIT;
                    end else if (r_qlen != '0) begin
                        n_state = S_EVRD;
                    end else begin
                        n_status = ST_ALL_PINNED;
                        n_state  = S_COMMIT;
                    end
                end
            end
            S_QRD: begin
                n_state = (QW'(r_qi) >= r_qlen) ? S_COMMIT : S_QCMP;
            end
            S_QCMP: begin
                if (r_q_rd == r_slot) begin
                    n_state = S_SHRD;
                end else if (r_qi == LAST_SLOT) begin
                    n_state = S_COMMIT;
                end else begin
                    n_qi    = r_qi + SW'(1);
                    n_state = S_QRD;
                end
            end
            S_SHRD: begin
                // close the gap one entry at a time
                if ((QW'(r_qi) + QW'(1)) >= r_qlen) begin
                    n_qlen  = r_qlen - QW'(1);
                    n_state = S_COMMIT;
                end else begin
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                n_qi    = r_qi + SW'(1);
                n_state = S_SHRD;
            end
            S_EVRD: begin
                n_state = S_EVSLOT;
            end
            S_EVSLOT: begin
                n_slot  = r_q_rd;
                n_state = S_EVKEY;
            end
            S_EVKEY: begin
                n_old_key = w_rd_key;
                n_evict   = 1'b1;
                n_cnt     = COUNT_BITS'(1);
                n_key_we  = 1'b1;
                n_cnt_we  = 1'b1;
                n_status  = ST_REPLACED;
                n_qi      = '0;
                n_state   = S_SHRD;
            end
            S_COMMIT: begin
                if (w_commit) begin
                    if (r_set_val) begin
                        n_used = r_used + QW'(1);
                    end
                    if (r_q_append && (r_qlen < SLOTS_Q)) begin
                        n_qlen = r_qlen + QW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_qlen  <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_qlen  <= n_qlen;
            r_used  <= n_used;
        end
        r_action   <= n_action;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_free     <= n_free;
        r_free_ok  <= n_free_ok;
        r_slot     <= n_slot;
        r_cnt      <= n_cnt;
        r_qi       <= n_qi;
        r_status   <= n_status;
        r_evict    <= n_evict;
        r_old_key  <= n_old_key;
        r_key_we   <= n_key_we;
        r_cnt_we   <= n_cnt_we;
        r_set_val  <= n_set_val;
        r_q_append <= n_q_append;
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    // response register, loaded at commit and held until taken
    assign w_slot_ext = (SLOT_W + SW)'(r_slot);
    assign w_cnt_ext  = (COUNT_W + COUNT_BITS)'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_commit) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
        if (w_commit) begin
            r_o_status <= r_status;
            r_o_slot   <= w_slot_ext[SLOT_W-1:0];
            r_o_count  <= w_cnt_ext[COUNT_W-1:0];
            r_o_evict  <= r_evict;
            r_o_key    <= KEY_W'(r_old_key);
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.slot          = r_o_slot;
    assign o_rsp.pin_count_now = r_o_count;
    assign o_rsp.evicted_valid = r_o_evict;
    assign o_rsp.evicted_key   = r_o_key;

`ifndef ASSERT_OFF
    // used count tracks the valid bits
    a_used_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_used))
        else $error("used slot count differs from valid bits");

    // queued slots are always slots in use
    a_queue_within_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qlen <= r_used)
        else $error("replacement queue longer than slots in use");

    // an accepted word starts the sequencer
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("sequencer idle after accepting a word");

    // eviction is reported only with a replacement
    a_evict_only_replaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.evicted_valid) |-> (o_rsp.status == ST_REPLACED))
        else $error("evicted key reported without replacement");
`endif

endmodule
